FILE: rtl/core/csmg_pkg.sv
// ----------------------------------------------------------------------------
// csmg_pkg: shared types for the cube store
// Word layouts of both channels and the read/write mode codes.
// ----------------------------------------------------------------------------
package csmg_pkg;

  typedef struct packed {
    logic        mode;
    logic [3:0]  cell_x;
    logic [3:0]  cell_y;
    logic [3:0]  cell_z;
    logic [31:0] write_value;
  } in_word_t;

  typedef struct packed {
    logic [31:0] cell_value;
    logic        index_ok;
    logic [31:0] mean_value;
    logic [31:0] core_geomean;
    logic [31:0] corner_origin;
    logic [31:0] corner_xy;
    logic [31:0] corner_xz;
    logic [31:0] corner_yz;
  } out_word_t;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

endpackage

FILE: rtl/core/csmg_ram.sv
// ----------------------------------------------------------------------------
// csmg_ram: generic single-port RAM
// One write or one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module csmg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/core/csmg_front.sv
// ----------------------------------------------------------------------------
// csmg_front: input queue
// Range-checks indices, flattens the address and holds words in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module csmg_front #(
  parameter int DIM = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  csmg_pkg::in_word_t           in_word,
  output logic                         cmd_valid,
  input  logic                         cmd_take,
  output logic                         cmd_ok,
  output logic                         cmd_write,
  output logic [$clog2(DIM*DIM*DIM)-1:0] cmd_addr,
  output logic [31:0]                  cmd_value
);

  localparam int AW = $clog2(DIM*DIM*DIM);
  localparam int QW = 1 + 1 + AW + 32;

  logic [QW-1:0] q_r [2];
  logic [QW-1:0] q_nxt;
  logic          rd_r, wr_r;
  logic [1:0]    cnt_r;
  logic          ok;
  logic [AW-1:0] addr;
  logic          push_ok, take_ok;

  assign ok = (32'(in_word.cell_x) < DIM) && (32'(in_word.cell_y) < DIM) &&
              (32'(in_word.cell_z) < DIM);
  assign addr = AW'((32'(in_word.cell_x) * DIM + 32'(in_word.cell_y)) * DIM
                    + 32'(in_word.cell_z));
  assign q_nxt = {ok, in_word.mode, ok ? addr : '0, in_word.write_value};

  assign in_full   = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign push_ok   = in_push && !in_full;
  assign take_ok   = cmd_take && cmd_valid;
  assign {cmd_ok, cmd_write, cmd_addr, cmd_value} = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_r] <= q_nxt;
    end
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_ok) wr_r <= !wr_r;
      if (take_ok) rd_r <= !rd_r;
      cnt_r <= cnt_r + {1'b0, push_ok} - {1'b0, take_ok};
    end
  end

endmodule

FILE: rtl/core/csmg_back.sv
// ----------------------------------------------------------------------------
// csmg_back: store sequencer
// Clears the store after reset, then runs each command: memory access,
// snapshot reads of the center and corner cells, multiply, mean and a
// bit-pair square root, and posts the result word.
// ----------------------------------------------------------------------------
module csmg_back #(
  parameter int DIM = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cmd_valid,
  output logic                           cmd_take,
  input  logic                           cmd_ok,
  input  logic                           cmd_write,
  input  logic [$clog2(DIM*DIM*DIM)-1:0] cmd_addr,
  input  logic [31:0]                    cmd_value,
  output logic                           out_empty,
  input  logic                           out_pop,
  output csmg_pkg::out_word_t            out_word
);

  localparam int NC   = DIM*DIM*DIM;
  localparam int AW   = $clog2(NC);
  localparam int LO   = (DIM-1)/2;
  localparam int HI   = DIM/2;
  localparam int LST  = DIM-1;
  localparam logic [AW-1:0] A_LO = AW'((LO*DIM+LO)*DIM+LO);
  localparam logic [AW-1:0] A_HI = AW'((HI*DIM+HI)*DIM+HI);
  localparam logic [AW-1:0] A_XY = AW'((LST*DIM+LST)*DIM);
  localparam logic [AW-1:0] A_XZ = AW'(LST*DIM*DIM+LST);
  localparam logic [AW-1:0] A_YZ = AW'(LST*DIM+LST);
  localparam logic [AW-1:0] A_END = AW'(NC-1);
  // Reciprocal of the cell count, rounded up, exact for every 42-bit sum.
  localparam int KSH = 42 + AW;
  localparam logic [42:0] RECIP =
    43'(((64'd1 << KSH) + 64'(NC) - 64'd1) / 64'(NC));

  typedef enum logic [8:0] {
    S_CLR  = 9'b000000001,
    S_IDLE = 9'b000000010,
    S_ACC  = 9'b000000100,
    S_RD   = 9'b000001000,
    S_MUL  = 9'b000010000,
    S_DIV  = 9'b000100000,
    S_SQRT = 9'b001000000,
    S_POST = 9'b010000000,
    S_WAIT = 9'b100000000
  } state_t;

  state_t        st_r, st_nxt;
  logic [AW-1:0] ptr_r;
  logic [2:0]    rk_r;
  logic          we;
  logic [AW-1:0] addr;
  logic [31:0]   wdata, rdata;
  logic [41:0]   sum_r;
  logic [31:0]   cell_r, clo_r, chi_r, c0_r, cxy_r, cxz_r, cyz_r;
  logic          ok_r, wr_r;
  logic [63:0]   rem_r, root_r, bit_r;
  logic [5:0]    step_r;
  logic [13:0]   sum_slice;
  logic [56:0]   prod;
  logic [85:0]   acc_r;
  logic [63:0]   trial;
  logic          full_r;

  csmg_ram #(.WIDTH(32), .DEPTH(NC)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign cmd_take  = (st_r == S_IDLE) && cmd_valid;
  assign out_empty = !full_r;

  always_comb begin
    we = 1'b0; addr = ptr_r; wdata = '0;
    unique case (st_r)
      S_CLR: begin
        we = 1'b1;
      end
      S_IDLE: begin
        addr  = cmd_addr;
        we    = cmd_valid && cmd_ok && (cmd_write == csmg_pkg::MODE_WRITE);
        wdata = cmd_value;
      end
      S_ACC, S_RD: begin
        unique case (rk_r)
          3'd0: addr = A_LO;
          3'd1: addr = A_HI;
          3'd2: addr = '0;
          3'd3: addr = A_XY;
          3'd4: addr = A_XZ;
          default: addr = A_YZ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (step_r[1:0])
      2'd0: sum_slice = sum_r[41:28];
      2'd1: sum_slice = sum_r[27:14];
      default: sum_slice = sum_r[13:0];
    endcase
  end

  assign prod  = {14'd0, RECIP} * {43'd0, sum_slice};
  assign trial = root_r + bit_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_CLR:  if (ptr_r == A_END) st_nxt = S_IDLE;
      S_IDLE: if (cmd_valid) st_nxt = S_ACC;
      S_ACC:  st_nxt = S_RD;
      S_RD:   if (rk_r == 3'd5) st_nxt = S_MUL;
      S_MUL:  st_nxt = S_DIV;
      S_DIV:  if (step_r == 6'd2) st_nxt = S_SQRT;
      S_SQRT: if (step_r == 6'd31) st_nxt = S_POST;
      S_POST: st_nxt = S_WAIT;
      S_WAIT: if (out_pop) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      S_IDLE: begin
        ok_r <= cmd_ok;
        wr_r <= cmd_write;
        rk_r <= 3'd0;
        if (cmd_valid && cmd_ok && (cmd_write == csmg_pkg::MODE_WRITE)) begin
          cell_r <= cmd_value;
        end
      end
      S_ACC: begin
        if (ok_r && wr_r == csmg_pkg::MODE_WRITE) begin
          sum_r <= sum_r - 42'(rdata) + 42'(cell_r);
        end else if (!ok_r) begin
          cell_r <= '0;
        end else begin
          cell_r <= rdata;
        end
        rk_r <= 3'd1;
      end
      S_RD: begin
        unique case (rk_r)
          3'd1: clo_r <= rdata;
          3'd2: chi_r <= rdata;
          3'd3: c0_r  <= rdata;
          3'd4: cxy_r <= rdata;
          3'd5: cxz_r <= rdata;
          default: ;
        endcase
        rk_r <= rk_r + 3'd1;
      end
      S_MUL: begin
        cyz_r  <= rdata;
        rem_r  <= 64'(clo_r) * 64'(chi_r);
        root_r <= '0;
        bit_r  <= 64'd1 << 62;
        acc_r  <= '0;
        step_r <= '0;
      end
      S_DIV: begin
        // Mean by reciprocal multiplication: the running sum is fed in
        // three 14-bit slices, top slice first, and the product is
        // shifted down by KSH when the result is posted.
        acc_r  <= {acc_r[71:0], 14'd0} + {29'd0, prod};
        step_r <= (step_r == 6'd2) ? 6'd0 : step_r + 6'd1;
      end
      S_SQRT: begin
        if (rem_r >= trial) begin
          rem_r  <= rem_r - trial;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r  <= bit_r >> 2;
        step_r <= step_r + 6'd1;
      end
      S_POST: begin
        out_word.cell_value    <= cell_r;
        out_word.index_ok      <= ok_r;
        out_word.mean_value    <= acc_r[KSH +: 32];
        out_word.core_geomean  <= root_r[31:0];
        out_word.corner_origin <= c0_r;
        out_word.corner_xy     <= cxy_r;
        out_word.corner_xz     <= cxz_r;
        out_word.corner_yz     <= cyz_r;
      end
      default: ;
    endcase
    if (!rst_n) begin
      st_r   <= S_CLR;
      ptr_r  <= '0;
      sum_r  <= '0;
      full_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_CLR) ptr_r <= ptr_r + AW'(1);
      if (st_r == S_POST) full_r <= 1'b1;
      else if (st_r == S_WAIT && out_pop) full_r <= 1'b0;
    end
  end

endmodule

FILE: rtl/core/cube_store_with_mean_and_geomean_top.sv
// ----------------------------------------------------------------------------
// cube_store_with_mean_and_geomean_top: cubic Q16.16 store with statistics
// Reads or writes one cell per word and reports mean, geomean and corners.
// ----------------------------------------------------------------------------
// After reset the block clears its DIM^3-entry store, one entry per cycle.
// During the clear the input queue accepts up to two words, but no work
// starts until the clear ends. Each word then passes through the back end
// in order: it takes the word and starts the memory access, finishes it,
// makes the snapshot reads of the center and corner cells, forms the 64-bit
// product of the center cells, the mean by reciprocal multiplication and
// the bit-pair square root, the longest step, then loads the output
// register and waits with the result. The result stays in the output
// register until popped, and the back end takes no new word meanwhile; the
// two-entry input queue keeps taking words until it is full.
// An index at or above DIM gives index_ok = 0 and cell_value = 0; the store
// is left untouched.
module cube_store_with_mean_and_geomean_top #(
  parameter int DIM = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  csmg_pkg::in_word_t   in_word,
  output logic                 out_empty,
  input  logic                 out_pop,
  output csmg_pkg::out_word_t  out_word
);

  localparam int AW = $clog2(DIM*DIM*DIM);

  logic          cmd_valid, cmd_take, cmd_ok, cmd_write;
  logic [AW-1:0] cmd_addr;
  logic [31:0]   cmd_value;

  // Front end: range check, address flattening and a two-word queue.
  csmg_front #(.DIM(DIM)) u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_word(in_word), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
    .cmd_ok(cmd_ok), .cmd_write(cmd_write), .cmd_addr(cmd_addr),
    .cmd_value(cmd_value)
  );

  // Back end: store, running sum and the arithmetic sequencer.
  csmg_back #(.DIM(DIM)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
    .cmd_ok(cmd_ok), .cmd_write(cmd_write), .cmd_addr(cmd_addr),
    .cmd_value(cmd_value), .out_empty(out_empty), .out_pop(out_pop),
    .out_word(out_word)
  );

endmodule
